// ----- rtl/bhi_pkg.sv -----
// ----------------------------------------------------------------------------
// bhi_pkg: shared types and constants
// Widths, payload structs and divider token for the barycentric height block.
// ----------------------------------------------------------------------------
`default_nettype none

package bhi_pkg;

  localparam int DW      = 32;
  localparam int FRAC_W  = 16;
  localparam int ONE_Q16 = 65536;
  localparam int DIFF_W  = DW + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DOT_W   = PROD_W + 1;
  localparam int MAG_W   = DOT_W - 1;
  localparam int HALF_W  = MAG_W / 2;
  localparam int MUL_W   = 2 * MAG_W + 1;
  localparam int NUM_W   = MUL_W + 1;
  localparam int DEN_W   = NUM_W - 2;
  localparam int DVD_W   = NUM_W - 1 + FRAC_W;
  localparam int QS_W    = DVD_W + 1;
  localparam int AQ_W    = QS_W + 2;
  localparam int NCELL   = DVD_W;

  typedef struct packed {
    logic signed [DW-1:0] point_x;
    logic signed [DW-1:0] point_y;
    logic signed [DW-1:0] point_z;
    logic signed [DW-1:0] vert_a_x;
    logic signed [DW-1:0] vert_a_y;
    logic signed [DW-1:0] vert_a_z;
    logic signed [DW-1:0] vert_b_x;
    logic signed [DW-1:0] vert_b_y;
    logic signed [DW-1:0] vert_b_z;
    logic signed [DW-1:0] vert_c_x;
    logic signed [DW-1:0] vert_c_y;
    logic signed [DW-1:0] vert_c_z;
  } query_t;

  typedef struct packed {
    logic signed [DW-1:0] weight_alpha;
    logic signed [DW-1:0] weight_beta;
    logic signed [DW-1:0] weight_gamma;
    logic signed [DW-1:0] height;
    logic                 degenerate;
  } result_t;

  typedef struct packed {
    logic signed [DW-1:0] ay;
    logic signed [DW-1:0] by;
    logic signed [DW-1:0] cy;
  } vert_y_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DVD_W-1:0] dq;
    logic             neg;
  } div_lane_t;

  typedef struct packed {
    logic             valid;
    logic             deg;
    logic [DEN_W-1:0] den;
    div_lane_t        lane_b;
    div_lane_t        lane_g;
    vert_y_t          y;
  } div_tok_t;

endpackage

`default_nettype wire

// ----- rtl/bhi_if.sv -----
// ----------------------------------------------------------------------------
// bhi_if: channel interfaces
// Valid/ready channels for query and result transactions.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhi_query_if;
  logic             valid;
  logic             ready;
  bhi_pkg::query_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bhi_result_if;
  logic             valid;
  logic             ready;
  bhi_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bhi_wmul.sv -----
// ----------------------------------------------------------------------------
// bhi_wmul: pipelined wide signed multiplier
// Three stages: magnitude and sign, four half-width partials, recombine.
// ----------------------------------------------------------------------------
`default_nettype none

module bhi_wmul (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [bhi_pkg::DOT_W-1:0]  a,
  input  logic signed [bhi_pkg::DOT_W-1:0]  b,
  output logic signed [bhi_pkg::MUL_W-1:0]  p
);

  logic [bhi_pkg::DOT_W-1:0]    abs_a, abs_b;
  logic [bhi_pkg::MAG_W-1:0]    ma, mb;
  logic                         neg1, neg2;
  logic [2*bhi_pkg::HALF_W-1:0] pll, plh, phl, phh;
  logic [2*bhi_pkg::MAG_W-1:0]  sum;

  assign abs_a = a[bhi_pkg::DOT_W-1] ? -a : a;
  assign abs_b = b[bhi_pkg::DOT_W-1] ? -b : b;

  assign sum = (2*bhi_pkg::MAG_W)'(pll)
             + ((2*bhi_pkg::MAG_W)'(plh) << bhi_pkg::HALF_W)
             + ((2*bhi_pkg::MAG_W)'(phl) << bhi_pkg::HALF_W)
             + ((2*bhi_pkg::MAG_W)'(phh) << (2*bhi_pkg::HALF_W));

  always_ff @(posedge clk) begin
    if (en) begin
      ma   <= abs_a[bhi_pkg::MAG_W-1:0];
      mb   <= abs_b[bhi_pkg::MAG_W-1:0];
      neg1 <= a[bhi_pkg::DOT_W-1] ^ b[bhi_pkg::DOT_W-1];
      pll  <= ma[bhi_pkg::HALF_W-1:0] * mb[bhi_pkg::HALF_W-1:0];
      plh  <= ma[bhi_pkg::HALF_W-1:0] * mb[bhi_pkg::MAG_W-1:bhi_pkg::HALF_W];
      phl  <= ma[bhi_pkg::MAG_W-1:bhi_pkg::HALF_W] * mb[bhi_pkg::HALF_W-1:0];
      phh  <= ma[bhi_pkg::MAG_W-1:bhi_pkg::HALF_W] * mb[bhi_pkg::MAG_W-1:bhi_pkg::HALF_W];
      neg2 <= neg1;
      p    <= neg2 ? -signed'({1'b0, sum}) : signed'({1'b0, sum});
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bhi_div_cell.sv -----
// ----------------------------------------------------------------------------
// bhi_div_cell: one restoring divide step
// Produces one quotient bit for each of the two lanes and passes the token on.
// ----------------------------------------------------------------------------
`default_nettype none

module bhi_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  bhi_pkg::div_tok_t tok_in,
  output bhi_pkg::div_tok_t tok_out
);

  bhi_pkg::div_tok_t tok_next;

  function automatic bhi_pkg::div_lane_t lane_step(input bhi_pkg::div_lane_t l,
                                                   input logic [bhi_pkg::DEN_W-1:0] den);
    logic [bhi_pkg::DEN_W:0]   sh;
    logic [bhi_pkg::DEN_W+1:0] diff;
    logic                      ge;
    bhi_pkg::div_lane_t        r;
    sh    = {l.rem, l.dq[bhi_pkg::DVD_W-1]};
    diff  = {1'b0, sh} - {2'b00, den};
    ge    = !diff[bhi_pkg::DEN_W+1];
    r.rem = ge ? diff[bhi_pkg::DEN_W-1:0] : sh[bhi_pkg::DEN_W-1:0];
    r.dq  = {l.dq[bhi_pkg::DVD_W-2:0], ge};
    r.neg = l.neg;
    return r;
  endfunction

  always_comb begin
    tok_next        = tok_in;
    tok_next.lane_b = lane_step(tok_in.lane_b, tok_in.den);
    tok_next.lane_g = lane_step(tok_in.lane_g, tok_in.den);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/barycentric_height_interp_top.sv -----
// ----------------------------------------------------------------------------
// barycentric_height_interp_top: barycentric weights and height of a point
// Dot products, wide multipliers, a divider cell chain and the weighted sum.
// ----------------------------------------------------------------------------
// One query transaction is taken every cycle and each gives one result; the
// whole pipeline holds while a result waits to be taken. The divider chain
// has 149 cells, one quotient bit of beta and of gamma in each cell; around it
// sit registered stages for the differences, products and dot products, the
// wide multipliers, the numerators and the dividends, and then for sign,
// weights, height products and output.
`default_nettype none

module barycentric_height_interp_top (
  input  logic                clk,
  input  logic                rst,
  bhi_query_if.sink           query,
  bhi_result_if.source        result
);

  logic en;
  assign en          = !result.valid || result.ready;
  assign query.ready = en;

  function automatic logic signed [bhi_pkg::DW-1:0] sat32(
      input logic signed [bhi_pkg::AQ_W-1:0] v);
    logic [bhi_pkg::AQ_W-bhi_pkg::DW:0] hi;
    hi = v[bhi_pkg::AQ_W-1:bhi_pkg::DW-1];
    if ((&hi) || !(|hi)) return v[bhi_pkg::DW-1:0];
    else if (v[bhi_pkg::AQ_W-1]) return {1'b1, {(bhi_pkg::DW-1){1'b0}}};
    else return {1'b0, {(bhi_pkg::DW-1){1'b1}}};
  endfunction

  // stage 1: difference vectors
  logic                             v1;
  logic signed [bhi_pkg::DIFF_W-1:0] ab [3];
  logic signed [bhi_pkg::DIFF_W-1:0] ac [3];
  logic signed [bhi_pkg::DIFF_W-1:0] ap [3];
  bhi_pkg::vert_y_t                  y1, y2, y3, y4, y5, y6, y7;

  // stage 2: products
  logic                              v2;
  logic signed [bhi_pkg::PROD_W-1:0] pr [15];

  // stage 3: dot products
  logic                             v3;
  logic signed [bhi_pkg::DOT_W-1:0] d00, d01, d11, d20, d21;

  // stages 4..6: wide multipliers
  logic                             v4, v5, v6;
  logic signed [bhi_pkg::MUL_W-1:0] mp [6];

  // stage 7: denominator and numerators
  logic                             v7;
  logic signed [bhi_pkg::NUM_W-1:0] den7, nb7, ng7;
  logic [bhi_pkg::NUM_W-1:0]        nb_mag, ng_mag;

  // divider chain
  bhi_pkg::div_tok_t chain [bhi_pkg::NCELL+1];
  bhi_pkg::div_tok_t tok0_next, tq;

  // quotient, weight, height stages
  logic                             vq, vw, vh;
  logic                             dq_deg, dw_deg, dh_deg;
  logic signed [bhi_pkg::QS_W-1:0]  bq, gq, qb_m, qg_m;
  bhi_pkg::vert_y_t                 yq, yw;
  logic signed [bhi_pkg::AQ_W-1:0]  aq;
  logic signed [bhi_pkg::DW-1:0]    wa, wb, wg, wah, wbh, wgh;
  logic signed [2*bhi_pkg::DW-1:0]  ha, hb, hc;
  logic signed [bhi_pkg::AQ_W-1:0]  hs;

  genvar k;
  generate
    for (k = 0; k < 6; k++) begin : g_mul
      logic signed [bhi_pkg::DOT_W-1:0] ma_in, mb_in;
      always_comb begin
        case (k)
          0: begin ma_in = d00; mb_in = d11; end
          1: begin ma_in = d01; mb_in = d01; end
          2: begin ma_in = d11; mb_in = d20; end
          3: begin ma_in = d01; mb_in = d21; end
          4: begin ma_in = d00; mb_in = d21; end
          default: begin ma_in = d01; mb_in = d20; end
        endcase
      end
      bhi_wmul u_mul (.clk(clk), .en(en), .a(ma_in), .b(mb_in), .p(mp[k]));
    end
    for (k = 0; k < bhi_pkg::NCELL; k++) begin : g_cell
      bhi_div_cell u_cell (.clk(clk), .rst(rst), .en(en),
                           .tok_in(chain[k]), .tok_out(chain[k+1]));
    end
  endgenerate

  assign nb_mag = nb7[bhi_pkg::NUM_W-1] ? -nb7 : nb7;
  assign ng_mag = ng7[bhi_pkg::NUM_W-1] ? -ng7 : ng7;

  always_comb begin
    tok0_next.valid      = v7;
    tok0_next.deg        = (den7 == '0);
    tok0_next.den        = den7[bhi_pkg::DEN_W-1:0];
    tok0_next.lane_b.rem = '0;
    tok0_next.lane_b.dq  = {nb_mag[bhi_pkg::NUM_W-2:0], {bhi_pkg::FRAC_W{1'b0}}};
    tok0_next.lane_b.neg = nb7[bhi_pkg::NUM_W-1];
    tok0_next.lane_g.rem = '0;
    tok0_next.lane_g.dq  = {ng_mag[bhi_pkg::NUM_W-2:0], {bhi_pkg::FRAC_W{1'b0}}};
    tok0_next.lane_g.neg = ng7[bhi_pkg::NUM_W-1];
    tok0_next.y          = y7;
  end

  assign tq   = chain[bhi_pkg::NCELL];
  assign qb_m = signed'({1'b0, tq.lane_b.dq});
  assign qg_m = signed'({1'b0, tq.lane_g.dq});
  assign aq   = (bhi_pkg::AQ_W)'(bhi_pkg::ONE_Q16) - (bhi_pkg::AQ_W)'(bq)
              - (bhi_pkg::AQ_W)'(gq);
  assign hs   = (bhi_pkg::AQ_W)'(ha) + (bhi_pkg::AQ_W)'(hb) + (bhi_pkg::AQ_W)'(hc);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      v5           <= 1'b0;
      v6           <= 1'b0;
      v7           <= 1'b0;
      chain[0].valid <= 1'b0;
      vq           <= 1'b0;
      vw           <= 1'b0;
      vh           <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      v1 <= query.valid;
      ab[0] <= (bhi_pkg::DIFF_W)'(query.data.vert_b_x) - (bhi_pkg::DIFF_W)'(query.data.vert_a_x);
      ab[1] <= (bhi_pkg::DIFF_W)'(query.data.vert_b_y) - (bhi_pkg::DIFF_W)'(query.data.vert_a_y);
      ab[2] <= (bhi_pkg::DIFF_W)'(query.data.vert_b_z) - (bhi_pkg::DIFF_W)'(query.data.vert_a_z);
      ac[0] <= (bhi_pkg::DIFF_W)'(query.data.vert_c_x) - (bhi_pkg::DIFF_W)'(query.data.vert_a_x);
      ac[1] <= (bhi_pkg::DIFF_W)'(query.data.vert_c_y) - (bhi_pkg::DIFF_W)'(query.data.vert_a_y);
      ac[2] <= (bhi_pkg::DIFF_W)'(query.data.vert_c_z) - (bhi_pkg::DIFF_W)'(query.data.vert_a_z);
      ap[0] <= (bhi_pkg::DIFF_W)'(query.data.point_x) - (bhi_pkg::DIFF_W)'(query.data.vert_a_x);
      ap[1] <= (bhi_pkg::DIFF_W)'(query.data.point_y) - (bhi_pkg::DIFF_W)'(query.data.vert_a_y);
      ap[2] <= (bhi_pkg::DIFF_W)'(query.data.point_z) - (bhi_pkg::DIFF_W)'(query.data.vert_a_z);
      y1.ay <= query.data.vert_a_y;
      y1.by <= query.data.vert_b_y;
      y1.cy <= query.data.vert_c_y;

      v2 <= v1;
      y2 <= y1;
      for (int i = 0; i < 3; i++) begin
        pr[i]      <= ab[i] * ab[i];
        pr[3 + i]  <= ab[i] * ac[i];
        pr[6 + i]  <= ac[i] * ac[i];
        pr[9 + i]  <= ap[i] * ab[i];
        pr[12 + i] <= ap[i] * ac[i];
      end

      v3  <= v2;
      y3  <= y2;
      d00 <= (bhi_pkg::DOT_W)'(pr[0])  + (bhi_pkg::DOT_W)'(pr[1])  + (bhi_pkg::DOT_W)'(pr[2]);
      d01 <= (bhi_pkg::DOT_W)'(pr[3])  + (bhi_pkg::DOT_W)'(pr[4])  + (bhi_pkg::DOT_W)'(pr[5]);
      d11 <= (bhi_pkg::DOT_W)'(pr[6])  + (bhi_pkg::DOT_W)'(pr[7])  + (bhi_pkg::DOT_W)'(pr[8]);
      d20 <= (bhi_pkg::DOT_W)'(pr[9])  + (bhi_pkg::DOT_W)'(pr[10]) + (bhi_pkg::DOT_W)'(pr[11]);
      d21 <= (bhi_pkg::DOT_W)'(pr[12]) + (bhi_pkg::DOT_W)'(pr[13]) + (bhi_pkg::DOT_W)'(pr[14]);

      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      y4 <= y3;
      y5 <= y4;
      y6 <= y5;

      v7   <= v6;
      y7   <= y6;
      den7 <= (bhi_pkg::NUM_W)'(mp[0]) - (bhi_pkg::NUM_W)'(mp[1]);
      nb7  <= (bhi_pkg::NUM_W)'(mp[2]) - (bhi_pkg::NUM_W)'(mp[3]);
      ng7  <= (bhi_pkg::NUM_W)'(mp[4]) - (bhi_pkg::NUM_W)'(mp[5]);

      chain[0] <= tok0_next;

      vq     <= tq.valid;
      dq_deg <= tq.deg;
      yq     <= tq.y;
      bq     <= tq.lane_b.neg ? -qb_m : qb_m;
      gq     <= tq.lane_g.neg ? -qg_m : qg_m;

      vw     <= vq;
      dw_deg <= dq_deg;
      yw     <= yq;
      wa     <= sat32(aq);
      wb     <= sat32((bhi_pkg::AQ_W)'(bq));
      wg     <= sat32((bhi_pkg::AQ_W)'(gq));

      vh     <= vw;
      dh_deg <= dw_deg;
      wah    <= wa;
      wbh    <= wb;
      wgh    <= wg;
      ha     <= wa * yw.ay;
      hb     <= wb * yw.by;
      hc     <= wg * yw.cy;

      result.valid <= vh;
      if (dh_deg) begin
        result.data <= '{weight_alpha: '0, weight_beta: '0, weight_gamma: '0,
                         height: '0, degenerate: 1'b1};
      end else begin
        result.data <= '{weight_alpha: wah, weight_beta: wbh, weight_gamma: wgh,
                         height: sat32(hs >>> bhi_pkg::FRAC_W), degenerate: 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/bhi_checker.sv -----
// ----------------------------------------------------------------------------
// bhi_checker: port-level assertions
// Checks result holding, degenerate outputs, reset and back-pressure of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bhi_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_ready,
  input  logic             r_valid,
  input  logic             r_ready,
  input  bhi_pkg::result_t r_data
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    r_valid && !r_ready |=> r_valid)
    else $error("result dropped while stalled");

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_data.degenerate |->
      (r_data.weight_alpha == 0 && r_data.weight_beta == 0 &&
       r_data.weight_gamma == 0 && r_data.height == 0))
    else $error("degenerate result with nonzero fields");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !r_valid)
    else $error("result valid after reset");

  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !r_valid |-> q_ready)
    else $error("query stalled with empty output");

endmodule

bind barycentric_height_interp_top bhi_checker u_bhi_checker (
  .clk     (clk),
  .rst     (rst),
  .q_ready (query.ready),
  .r_valid (result.valid),
  .r_ready (result.ready),
  .r_data  (result.data)
);

`default_nettype wire
